FILE: rtl/core/cpi_pkg.sv
// ----------------------------------------------------------------------------
// cpi_pkg: shared types for the color palette indexer
// Field widths, action codes and the result record.
// ----------------------------------------------------------------------------
package cpi_pkg;

  localparam int COLOR_W = 24;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic {
    ACTION_MAP   = 1'b0,
    ACTION_CLEAR = 1'b1
  } action_t;

  typedef struct packed {
    index_t palette_index;
    logic   is_new;
    logic   table_overflow;
    count_t color_count;
  } result_t;

endpackage

FILE: rtl/core/cpi_if.sv
// ----------------------------------------------------------------------------
// cpi_if: channels of the color palette indexer
// Pixel request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpi_pixel_if;
  logic            valid;
  logic            ready;
  logic            action;
  cpi_pkg::color_t pixel_color;

  modport source (output valid, output action, output pixel_color, input ready);
  modport sink (input valid, input action, input pixel_color, output ready);
endinterface

interface cpi_result_if;
  logic            valid;
  logic            ready;
  cpi_pkg::index_t palette_index;
  logic            is_new;
  logic            table_overflow;
  cpi_pkg::count_t color_count;

  modport source (
    output valid, output palette_index, output is_new, output table_overflow,
    output color_count, input ready
  );
  modport sink (
    input valid, input palette_index, input is_new, input table_overflow,
    input color_count, output ready
  );
endinterface

FILE: rtl/core/color_palette_indexer.sv
// ----------------------------------------------------------------------------
// color_palette_indexer: first-seen palette index for a pixel color stream
// Associative lookup over the stored colors, append of new colors, clear.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   pixel    in   action, pixel_color
//   result   out  palette_index, is_new, table_overflow, color_count
//
// one request per cycle sustained while the result is not stalled; each request
// passes the request register, then the result register; the lookup compares
// all stored entries in parallel and appends in the same cycle
// rst clears the color count and both valid flags; the color store needs none
// a stalled result holds the result register; a new request is still taken
// whenever the request stage moves on in that cycle
// ----------------------------------------------------------------------------
module color_palette_indexer #(
  parameter int PALETTE_DEPTH = 256,
  parameter int COLOR_BITS    = 24
) (
  input logic           clk,
  input logic           rst,
  cpi_pixel_if.sink     pixel,
  cpi_result_if.source  result
);

  localparam int STORE_BITS = (COLOR_BITS < cpi_pkg::COLOR_W) ? COLOR_BITS : cpi_pkg::COLOR_W;
  localparam int IDX_W      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(PALETTE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PALETTE_DEPTH);

  logic                     s1_valid;
  cpi_pkg::action_t         s1_action;
  logic [STORE_BITS-1:0]    s1_color;
  logic [STORE_BITS-1:0]    palette [PALETTE_DEPTH];
  logic [CNT_W-1:0]         entries_used;
  logic [CNT_W-1:0]         entries_used_next;
  logic                     out_valid;
  cpi_pkg::result_t         out_res;
  cpi_pkg::result_t         out_res_next;

  logic                     s1_adv;
  logic [PALETTE_DEPTH-1:0] match;
  logic [IDX_W-1:0]         hit_idx;
  logic                     found;
  logic                     full;
  logic                     wr_en;

  assign s1_adv      = s1_valid && (!out_valid || result.ready);
  assign pixel.ready = !s1_valid || s1_adv;

  // parallel compare over occupied entries
  always_comb begin
    match   = '0;
    hit_idx = '0;
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      if ((CNT_W'(i) < entries_used) && (palette[i] == s1_color)) begin
        match[i] = 1'b1;
        hit_idx  = hit_idx | IDX_W'(i);
      end
    end
  end

  assign found = |match;
  assign full  = (entries_used == FULL_COUNT);

  always_comb begin
    out_res_next      = '0;
    entries_used_next = entries_used;
    wr_en             = 1'b0;
    unique case (s1_action)
      cpi_pkg::ACTION_CLEAR: begin
        entries_used_next = '0;
      end
      cpi_pkg::ACTION_MAP: begin
        priority if (found) begin
          out_res_next.palette_index = cpi_pkg::index_t'(hit_idx);
          out_res_next.color_count   = cpi_pkg::count_t'(entries_used);
        end else if (!full) begin
          out_res_next.palette_index = cpi_pkg::index_t'(entries_used[IDX_W-1:0]);
          out_res_next.is_new        = 1'b1;
          entries_used_next          = entries_used + CNT_W'(1);
          out_res_next.color_count   = cpi_pkg::count_t'(entries_used_next);
          wr_en                      = 1'b1;
        end else begin
          out_res_next.table_overflow = 1'b1;
          out_res_next.color_count    = cpi_pkg::count_t'(entries_used);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s1_action    <= cpi_pkg::ACTION_MAP;
      out_valid    <= 1'b0;
      entries_used <= '0;
    end else begin
      if (pixel.ready) begin
        s1_valid <= pixel.valid;
      end
      if (pixel.valid && pixel.ready) begin
        s1_action <= cpi_pkg::action_t'(pixel.action);
      end
      if (s1_adv) begin
        out_valid    <= 1'b1;
        entries_used <= entries_used_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      s1_color  <= pixel.pixel_color[STORE_BITS-1:0];
    end
    if (s1_adv) begin
      out_res <= out_res_next;
    end
    if (s1_adv && wr_en) begin
      palette[entries_used[IDX_W-1:0]] <= s1_color;
    end
  end

  assign result.valid          = out_valid;
  assign result.palette_index  = out_res.palette_index;
  assign result.is_new         = out_res.is_new;
  assign result.table_overflow = out_res.table_overflow;
  assign result.color_count    = out_res.color_count;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entries_used <= FULL_COUNT)
    else $error("color count beyond palette depth");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("color stored twice in palette");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    s1_adv && wr_en |=> entries_used == $past(entries_used) + CNT_W'(1))
    else $error("append did not advance color count");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_action == cpi_pkg::ACTION_CLEAR) |=> entries_used == '0)
    else $error("clear left colors in palette");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.table_overflow |->
      result.color_count == cpi_pkg::count_t'(PALETTE_DEPTH) && !result.is_new)
    else $error("overflow reported on a palette that is not full");
`endif

endmodule
